// File: src/pwvm_pkg.sv
`default_nettype none
package pwvm_pkg;

    // Field widths
    localparam int PHASE_W    = 16;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int STATUS_W   = 8;
    localparam int SAMPLE_W   = 22;
    localparam int NOTE_COUNT = 128;
    localparam int HZ_W       = 14;

    // Step scale: phase units per Hz per second, just under two turns of the 16-bit phase
    localparam longint unsigned PHASE_SCALE = (64'd1 << 17) - 64'd1;

    // Square table levels (25% duty)
    localparam int SQ_LOW  = -16384;
    localparam int SQ_HIGH = 16383;

    // Opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MIDI = 1'b1;

    // MIDI status kinds (high nibble)
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

    // Note frequency in whole Hz, equal temperament from A4 = 440 Hz
    localparam logic [HZ_W-1:0] NOTE_HZ [NOTE_COUNT] = '{
        14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12, 14'd13,
        14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19, 14'd20, 14'd21, 14'd23, 14'd24,
        14'd25, 14'd27, 14'd29, 14'd30, 14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43,
        14'd46, 14'd48, 14'd51, 14'd55, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
        14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd110, 14'd116, 14'd123, 14'd130,
        14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195, 14'd207, 14'd220,
        14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311, 14'd329, 14'd349, 14'd369,
        14'd391, 14'd415, 14'd440, 14'd466, 14'd493, 14'd523, 14'd554, 14'd587, 14'd622,
        14'd659, 14'd698, 14'd739, 14'd783, 14'd830, 14'd880, 14'd932, 14'd987,
        14'd1046, 14'd1108, 14'd1174, 14'd1244, 14'd1318, 14'd1396, 14'd1479, 14'd1567,
        14'd1661, 14'd1760, 14'd1864, 14'd1975, 14'd2093, 14'd2217, 14'd2349, 14'd2489,
        14'd2637, 14'd2793, 14'd2959, 14'd3135, 14'd3322, 14'd3520, 14'd3729, 14'd3951,
        14'd4186, 14'd4434, 14'd4698, 14'd4978, 14'd5274, 14'd5587, 14'd5919, 14'd6271,
        14'd6644, 14'd7040, 14'd7458, 14'd7902, 14'd8372, 14'd8869, 14'd9397, 14'd9956,
        14'd10548, 14'd11175, 14'd11839, 14'd12543
    };

    // Write command to the voice store (one address per cycle)
    typedef struct packed {
        logic               phase_en;
        logic               note_en;
        logic               act_en;
        logic               act_val;
        logic [PHASE_W-1:0] phase;
        logic [NOTE_W-1:0]  note;
    } voice_wr_t;

endpackage
`default_nettype wire

// File: src/pwvm_step_rom.sv
`default_nettype none
module pwvm_step_rom
    import pwvm_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = 32000
)
(
    input  wire logic [NOTE_W-1:0]  note,
    output logic      [PHASE_W-1:0] step
);

    logic [PHASE_W-1:0] step_rom [NOTE_COUNT];

    // Build the phase step of each note; only the low bits matter as the phase wraps
    for (genvar n = 0; n < NOTE_COUNT; n++)
    begin : g_step
        localparam longint unsigned STEP_FULL =
            (longint'(NOTE_HZ[n]) * PHASE_SCALE) / longint'(SAMPLE_RATE_HZ);
        assign step_rom[n] = PHASE_W'(STEP_FULL);
    end

    assign step = step_rom[note];

endmodule
`default_nettype wire

// File: src/pwvm_voice_store.sv
`default_nettype none
module pwvm_voice_store
    import pwvm_pkg::*;
#(
    parameter int VOICE_COUNT = 128,
    parameter int IDX_W       = 7
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [IDX_W-1:0]   rd_addr,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire voice_wr_t          wr,
    output logic      [PHASE_W-1:0] rd_phase,
    output logic      [NOTE_W-1:0]  rd_note,
    output logic                    rd_active
);

    logic [PHASE_W-1:0]     phase_mem [VOICE_COUNT];
    logic [NOTE_W-1:0]      note_mem  [VOICE_COUNT];
    logic [PHASE_W-1:0]     phase_q_reg;
    logic [NOTE_W-1:0]      note_q_reg;
    logic [VOICE_COUNT-1:0] phase_ok_reg;
    logic [VOICE_COUNT-1:0] note_ok_reg;
    logic [VOICE_COUNT-1:0] active_reg;
    logic                   phase_ok_q_reg;
    logic                   note_ok_q_reg;
    logic                   active_q_reg;

    // Phase and note memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.phase_en)
        begin
            phase_mem[wr_addr] <= wr.phase;
        end
        if (wr.note_en)
        begin
            note_mem[wr_addr] <= wr.note;
        end
        phase_q_reg <= phase_mem[rd_addr];
        note_q_reg  <= note_mem[rd_addr];
    end

    // Written marks and active flags; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ok_reg   <= '0;
            note_ok_reg    <= '0;
            active_reg     <= '0;
            phase_ok_q_reg <= 1'b0;
            note_ok_q_reg  <= 1'b0;
            active_q_reg   <= 1'b0;
        end
        else
        begin
            if (wr.phase_en)
            begin
                phase_ok_reg[wr_addr] <= 1'b1;
            end
            if (wr.note_en)
            begin
                note_ok_reg[wr_addr] <= 1'b1;
            end
            if (wr.act_en)
            begin
                active_reg[wr_addr] <= wr.act_val;
            end
            phase_ok_q_reg <= phase_ok_reg[rd_addr];
            note_ok_q_reg  <= note_ok_reg[rd_addr];
            active_q_reg   <= active_reg[rd_addr];
        end
    end

    assign rd_phase  = phase_ok_q_reg ? phase_q_reg : '0;
    assign rd_note   = note_ok_q_reg ? note_q_reg : '0;
    assign rd_active = active_q_reg;

endmodule
`default_nettype wire

// File: src/polyphonic_wavetable_voice_mixer.sv
// Tick: one voice per cycle through the voice store read port and the shared phase adder;
//   the result waits in ST_DONE while an earlier result beat is still stalled.
// MIDI note-on/off: one voice per cycle through the note compare.
// Other status bytes are taken and give no beat. One item at a time; in_stall is
// high in every state but idle. A pending result beat does not block the next item.
// Reset (rst_n, asynchronous): every voice inactive with note 0 and phase 0, no beat.
`default_nettype none
module polyphonic_wavetable_voice_mixer
    import pwvm_pkg::*;
#(
    parameter int VOICE_COUNT    = 128,
    parameter int SAMPLE_RATE_HZ = 32000
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       opcode,
    input  wire logic [STATUS_W-1:0]        midi_status,
    input  wire logic [NOTE_W-1:0]          note_number,
    input  wire logic [VEL_W-1:0]           velocity,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [SAMPLE_W-1:0]      mixed_sample
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIDI,
        ST_APPLY,
        ST_TICK,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic                        is_on_reg, is_on_next;
    logic [NOTE_W-1:0]           note_reg, note_next;
    logic [IDX_W-1:0]            iss_idx_reg, iss_idx_next;
    logic                        iss_run_reg, iss_run_next;
    logic                        p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]            p_idx_reg, p_idx_next;
    logic                        match_found_reg, match_found_next;
    logic [IDX_W-1:0]            match_idx_reg, match_idx_next;
    logic                        free_found_reg, free_found_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic signed [SAMPLE_W-1:0]  sum_reg, sum_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]  mixed_reg, mixed_next;

    logic [3:0]                  kind;
    logic                        msg_on;
    logic                        msg_off;
    logic                        last_voice;
    logic [PHASE_W-1:0]          rd_phase;
    logic [NOTE_W-1:0]           rd_note;
    logic                        rd_active;
    logic [PHASE_W-1:0]          step;
    logic signed [SAMPLE_W-1:0]  sq_value;
    logic [IDX_W-1:0]            wr_addr;
    voice_wr_t                   wr;

    // Decode the MIDI beat
    assign kind    = midi_status[STATUS_W-1 -: 4];
    assign msg_on  = (kind == KIND_NOTE_ON) && (velocity != '0);
    assign msg_off = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (velocity == '0));

    assign last_voice = p_vld_reg && (p_idx_reg == LAST_IDX);

    // Top quarter of the table is high, for any table size of four or more
    assign sq_value = (rd_phase[PHASE_W-1] && rd_phase[PHASE_W-2])
                    ? SAMPLE_W'(SQ_HIGH) : SAMPLE_W'(SQ_LOW);

    pwvm_step_rom #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_step_rom (
        .note (rd_note),
        .step (step)
    );

    pwvm_voice_store #(
        .VOICE_COUNT (VOICE_COUNT),
        .IDX_W       (IDX_W)
    ) u_voice_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (iss_idx_reg),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .rd_phase  (rd_phase),
        .rd_note   (rd_note),
        .rd_active (rd_active)
    );

    // Voice store writes: phase advance on a tick walk, activation, release or allocation after a MIDI walk
    always_comb
    begin
        wr          = '0;
        wr.phase    = rd_phase + step;
        wr.note     = note_reg;
        wr_addr     = p_idx_reg;
        if (state_reg == ST_TICK)
        begin
            wr.phase_en = p_vld_reg && rd_active;
        end
        else if (state_reg == ST_APPLY)
        begin
            wr_addr    = match_found_reg ? match_idx_reg : free_idx_reg;
            wr.act_en  = match_found_reg || (is_on_reg && free_found_reg);
            wr.act_val = match_found_reg ? is_on_reg : 1'b1;
            wr.note_en = !match_found_reg && is_on_reg && free_found_reg;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        is_on_next       = is_on_reg;
        note_next        = note_reg;
        iss_idx_next     = iss_idx_reg;
        iss_run_next     = iss_run_reg;
        p_vld_next       = 1'b0;
        p_idx_next       = p_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_valid_reg;
        mixed_next       = mixed_reg;

        // Drop the result beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Advance the voice walk: issue one read per cycle
        if (iss_run_reg)
        begin
            p_vld_next = 1'b1;
            p_idx_next = iss_idx_reg;
            if (iss_idx_reg == LAST_IDX)
            begin
                iss_run_next = 1'b0;
            end
            else
            begin
                iss_idx_next = iss_idx_reg + IDX_W'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_TICK)
                    begin
                        sum_next     = '0;
                        iss_idx_next = '0;
                        iss_run_next = 1'b1;
                        state_next   = ST_TICK;
                    end
                    else if (msg_on || msg_off)
                    begin
                        is_on_next       = msg_on;
                        note_next        = note_number;
                        match_found_next = 1'b0;
                        free_found_next  = 1'b0;
                        iss_idx_next     = '0;
                        iss_run_next     = 1'b1;
                        state_next       = ST_MIDI;
                    end
                end
            end
            ST_MIDI:
            begin
                // Hold the first matching voice and the first free voice
                if (p_vld_reg)
                begin
                    if (!match_found_reg && (rd_note == note_reg))
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = p_idx_reg;
                    end
                    if (!free_found_reg && !rd_active)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = p_idx_reg;
                    end
                end
                if (last_voice)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                // Accumulate active voices, wrapping at the sample width
                if (p_vld_reg && rd_active)
                begin
                    sum_next = sum_reg + sq_value;
                end
                if (last_voice)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    mixed_next     = sum_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            iss_run_reg     <= 1'b0;
            iss_idx_reg     <= '0;
            p_vld_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            iss_run_reg     <= iss_run_next;
            iss_idx_reg     <= iss_idx_next;
            p_vld_reg       <= p_vld_next;
            out_valid_reg   <= out_valid_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        is_on_reg     <= is_on_next;
        note_reg      <= note_next;
        p_idx_reg     <= p_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        sum_reg       <= sum_next;
        mixed_reg     <= mixed_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;

endmodule
`default_nettype wire

// File: src/pwvm_checker.sv
`default_nettype none
module pwvm_assertions
    import pwvm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  opcode,
    input wire logic [STATUS_W-1:0]   midi_status,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [SAMPLE_W-1:0]   mixed_sample
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mixed_sample))
        else $error("stalled result beat changed");

    // A tick beat starts a voice walk
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_TICK) |=> in_stall)
        else $error("tick beat did not start a walk");

    // A note-on or note-off beat starts a voice walk
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_MIDI)
        && ((midi_status[7:4] == KIND_NOTE_ON) || (midi_status[7:4] == KIND_NOTE_OFF))
        |=> in_stall)
        else $error("note beat did not start a walk");

    // A result beat only appears at the end of a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat without a walk");

endmodule

bind polyphonic_wavetable_voice_mixer pwvm_assertions u_pwvm_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .midi_status  (midi_status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mixed_sample (mixed_sample)
);
`default_nettype wire

// File: dv/pwvm_checker.sv
`default_nettype none
module pwvm_checker
    import pwvm_pkg::*;
#(
    parameter int VOICE_COUNT    = 128,
    parameter int SAMPLE_RATE_HZ = 32000,
    parameter int TABLE_BITS     = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic                   opcode,
    input  wire logic [STATUS_W-1:0]    midi_status,
    input  wire logic [NOTE_W-1:0]      note_number,
    input  wire logic [VEL_W-1:0]       velocity,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [SAMPLE_W-1:0]    mixed_sample,
    input  wire logic                   run_done,
    output int                          fail_count,
    output int                          pending,
    output int                          tick_beats,
    output int                          midi_beats,
    output int                          samples_checked,
    output int                          peak_sounding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow voice bank
    logic [PHASE_W-1:0] osc_phase [VOICE_COUNT];
    logic [NOTE_W-1:0]  osc_note  [VOICE_COUNT];
    logic               osc_on    [VOICE_COUNT];
    logic [PHASE_W-1:0] phase_inc [NOTE_COUNT];

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    bit                         closed;

    // Build the per-note phase increment from the whole-Hz note table
    initial
    begin
        for (int n = 0; n < NOTE_COUNT; n++)
        begin
            phase_inc[n] = PHASE_W'((64'(NOTE_HZ[n]) * PHASE_SCALE)
                                    / 64'(SAMPLE_RATE_HZ));
        end
    end

    task automatic report_mismatch(input string what);
        $display("checker @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Sum the square level of every sounding voice, then advance those phases
    function automatic logic signed [SAMPLE_W-1:0] mix_voices();
        int          acc;
        int unsigned slot;
        acc = 0;
        for (int v = 0; v < VOICE_COUNT; v++)
        begin
            if (osc_on[v])
            begin
                slot = osc_phase[v] >> (PHASE_W - TABLE_BITS);
                acc += (slot >= 3 * ((1 << TABLE_BITS) / 4)) ? SQ_HIGH : SQ_LOW;
                osc_phase[v] = osc_phase[v] + phase_inc[osc_note[v]];
            end
        end
        return SAMPLE_W'(acc);
    endfunction

    // Update the voice bank for one MIDI beat
    task automatic apply_midi(input logic [STATUS_W-1:0] st, input logic [NOTE_W-1:0] nt,
                              input logic [VEL_W-1:0] vl);
        logic [3:0] kind;
        logic       key_down;
        logic       key_up;
        int         hit;
        int         sounding;
        kind     = st[7:4];
        key_down = (kind == KIND_NOTE_ON) && (vl != '0);
        key_up   = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (vl == '0));
        hit      = -1;
        if (key_down || key_up)
        begin
            // First voice holding the note wins, sounding or not
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                if (hit < 0 && osc_note[v] == nt)
                    hit = v;
            end
            if (hit >= 0)
                osc_on[hit] = key_down;
            else if (key_down)
            begin
                // Take the first silent voice; drop the note if none is free
                for (int v = 0; v < VOICE_COUNT; v++)
                begin
                    if (hit < 0 && !osc_on[v])
                        hit = v;
                end
                if (hit >= 0)
                begin
                    osc_note[hit] = nt;
                    osc_on[hit]   = 1'b1;
                end
            end
        end
        sounding = 0;
        for (int v = 0; v < VOICE_COUNT; v++)
            sounding += osc_on[v];
        if (sounding > peak_sounding)
            peak_sounding = sounding;
    endtask

    // Watch both channels: predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                osc_phase[v] = '0;
                osc_note[v]  = '0;
                osc_on[v]    = 1'b0;
            end
            expected_samples.delete();
            closed          = 1'b0;
            fail_count      = 0;
            tick_beats      = 0;
            midi_beats      = 0;
            samples_checked = 0;
            peak_sounding   = 0;
            pending        <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("sample beat %0d with nothing expected",
                                              $signed(mixed_sample)));
                else
                begin
                    if ($signed(mixed_sample) !== expected_samples[0])
                        report_mismatch($sformatf("mixed_sample got %0d expected %0d",
                                                  $signed(mixed_sample), expected_samples[0]));
                    void'(expected_samples.pop_front());
                    samples_checked++;
                end
            end

            if (in_valid && !in_stall)
            begin
                if (opcode == OP_TICK)
                begin
                    expected_samples.push_back(mix_voices());
                    tick_beats++;
                end
                else
                begin
                    apply_midi(midi_status, note_number, velocity);
                    midi_beats++;
                end
            end

            // Flag samples that never turned up
            if (run_done && !closed)
            begin
                closed = 1'b1;
                if (expected_samples.size() != 0)
                    report_mismatch($sformatf("%0d expected samples never arrived",
                                              expected_samples.size()));
            end

            pending <= expected_samples.size();
        end
    end

endmodule
`default_nettype wire

// File: dv/polyphonic_wavetable_voice_mixer_test.sv
`default_nettype none
module polyphonic_wavetable_voice_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pwvm_pkg::*;

    localparam int VOICES       = 128;
    localparam int RATE_HZ      = 32000;
    localparam int RANDOM_BEATS = 500;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   opcode      = OP_TICK;
    logic [STATUS_W-1:0]    midi_status = '0;
    logic [NOTE_W-1:0]      note_number = '0;
    logic [VEL_W-1:0]       velocity    = '0;
    logic                   out_stall   = 1'b0;
    logic                   run_done    = 1'b0;
    wire logic              in_stall;
    wire logic              out_valid;
    wire logic [SAMPLE_W-1:0] mixed_sample;

    int fail_count;
    int pending;
    int tick_beats;
    int midi_beats;
    int samples_checked;
    int peak_sounding;

    // No idling on either side while set
    bit calm = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    polyphonic_wavetable_voice_mixer #(
        .VOICE_COUNT    (VOICES),
        .SAMPLE_RATE_HZ (RATE_HZ)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .midi_status  (midi_status),
        .note_number  (note_number),
        .velocity     (velocity),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mixed_sample (mixed_sample)
    );

    pwvm_checker #(
        .VOICE_COUNT    (VOICES),
        .SAMPLE_RATE_HZ (RATE_HZ),
        .TABLE_BITS     (4)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .midi_status     (midi_status),
        .note_number     (note_number),
        .velocity        (velocity),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mixed_sample    (mixed_sample),
        .run_done        (run_done),
        .fail_count      (fail_count),
        .pending         (pending),
        .tick_beats      (tick_beats),
        .midi_beats      (midi_beats),
        .samples_checked (samples_checked),
        .peak_sounding   (peak_sounding)
    );

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input logic op, input logic [STATUS_W-1:0] st,
                             input logic [NOTE_W-1:0] nt, input logic [VEL_W-1:0] vl);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        midi_status <= st;
        note_number <= nt;
        velocity    <= vl;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_tick();
        send_beat(OP_TICK, STATUS_W'($urandom), NOTE_W'($urandom), VEL_W'($urandom));
    endtask

    // Stall the sample side for a random spell, then take one beat
    initial
    begin
        int hold;
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        int                  pick;
        logic [NOTE_W-1:0]   nt;
        logic [3:0]          chan;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Silent bank, then note 0 which every voice holds after reset
        send_beat(OP_TICK, '0, '0, '0);
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127);
        send_tick();
        send_beat(OP_TICK, 8'hFF, 7'd127, 7'd127);
        // Free voice 0, let a new note take it, then wake the next note-0 voice
        send_beat(OP_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'hF}, 7'd5, 7'd1);
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'h3}, 7'd0, 7'd64);
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'h5}, 7'd127, 7'd127);
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'h9}, 7'd69, 7'd100);
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'hC}, 7'd69, 7'd100);
        send_tick();
        // Zero-velocity note-on releases; a note-off for an unheld note takes nothing
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'h1}, 7'd69, 7'd0);
        send_beat(OP_MIDI, {KIND_NOTE_OFF, 4'hF}, 7'd100, 7'd127);
        // Other status bytes are ignored
        send_beat(OP_MIDI, 8'hB0, 7'd1, 7'd1);
        send_beat(OP_MIDI, 8'h00, 7'd127, 7'd127);
        send_beat(OP_MIDI, 8'hFF, 7'd0, 7'd0);
        send_beat(OP_MIDI, 8'h7F, 7'd42, 7'd42);
        send_tick();
        send_beat(OP_MIDI, {KIND_NOTE_OFF, 4'h2}, 7'd127, 7'd64);
        send_tick();
        send_beat(OP_MIDI, {KIND_NOTE_ON, 4'hA}, 7'd100, 7'd127);
        send_tick();
        send_tick();

        // Random traffic: mostly note traffic and ticks, a little noise
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            chan = 4'($urandom);
            nt   = $urandom_range(0, 1) ? NOTE_W'($urandom) : NOTE_W'($urandom_range(60, 75));
            if (pick < 40)
                send_tick();
            else if (pick < 75)
                send_beat(OP_MIDI, {KIND_NOTE_ON, chan}, nt, VEL_W'($urandom_range(1, 127)));
            else if (pick < 83)
                send_beat(OP_MIDI, {KIND_NOTE_ON, chan}, nt, '0);
            else if (pick < 94)
                send_beat(OP_MIDI, {KIND_NOTE_OFF, chan}, nt, VEL_W'($urandom));
            else
                send_beat(OP_MIDI, STATUS_W'($urandom), nt, VEL_W'($urandom));
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // Drain, then allow a last walk to finish
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (VOICES + 24) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("run: %0d beats in (%0d ticks, %0d MIDI), %0d samples compared",
                 tick_beats + midi_beats, tick_beats, midi_beats, samples_checked);
        $display("run: up to %0d of %0d voices sounding at once", peak_sounding, VOICES);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
